// ----- sv/peu_pkg.sv -----
// Shared types, widths and codes for the multi-peak utility evaluator.
package peu_pkg;

	localparam int MAX_COMP_DEF = 8;

	localparam int POS_W = 24;
	localparam int SPAN_W = 23;
	localparam int UTIL_W = 16;
	localparam int DROP_W = 16;
	localparam int SLOPE_W = 32;
	localparam int IX_W = 16;
	localparam int CNT_W = 17;
	localparam int CC_W = 4;
	localparam int SLOT_W = 3;
	localparam int OUT_W = 19;
	localparam int CFG_W = 24;
	localparam int CFG_IX_W = 3;

	// point position, distance, fall and per-lane value widths
	localparam int PPOS_W = 41;
	localparam int DIST_W = 44;
	localparam int FALL_W = 39;
	localparam int LV_W = 24;
	localparam int LV_FLOOR = -(2 ** 22);

	localparam int OUT_MIN = -262144;
	localparam int OUT_MAX = 262143;

	localparam logic signed [UTIL_W-1:0] UTIL_RESET_MAX = 16'sd25600;

	// register indexes
	localparam logic [CFG_IX_W-1:0] REG_DOMAIN_LOW = 3'd0;
	localparam logic [CFG_IX_W-1:0] REG_DOMAIN_HIGH = 3'd1;
	localparam logic [CFG_IX_W-1:0] REG_DOMAIN_STEP = 3'd2;
	localparam logic [CFG_IX_W-1:0] REG_DOMAIN_COUNT = 3'd3;
	localparam logic [CFG_IX_W-1:0] REG_WRAP_ENABLE = 3'd4;
	localparam logic [CFG_IX_W-1:0] REG_COMBINE_MAX = 3'd5;
	localparam logic [CFG_IX_W-1:0] REG_COMP_COUNT = 3'd6;

	typedef enum logic {
		OP_EVAL = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_REJECT = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RG_PEAK,
		RG_BASE,
		RG_MIN
	} region_t;

	typedef enum logic [1:0] {
		LD_IDLE,
		LD_DIV,
		LD_COMMIT
	} ld_state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] summit;
		logic [SPAN_W-1:0] peak_span;
		logic [SPAN_W-1:0] base_span;
		logic [DROP_W-1:0] drop;
		logic signed [UTIL_W-1:0] umin;
		logic signed [UTIL_W-1:0] umax;
		logic [SLOPE_W-1:0] peak_slope;
		logic [SLOPE_W-1:0] base_slope;
	} comp_t;

	typedef struct packed {
		logic signed [POS_W-1:0] low;
		logic signed [POS_W-1:0] high;
		logic [SPAN_W-1:0] step;
		logic wrap;
	} dom_cfg_t;

endpackage

// ----- sv/peu_div.sv -----
// Restoring divider, one quotient bit per cycle, for the slope calculation.
module peu_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);
	import peu_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [CW-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] trial;
	logic take;

	// trial subtract of the next dividend bit
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		take = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NUM_W-2:0], take};
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quo = quo_q;

endmodule

// ----- sv/peu_lane.sv -----
// One component lane: distance, fall multiply and capped value, three stages.
module peu_lane (
	input  logic                            clk,
	input  logic                            adv,
	input  logic signed [peu_pkg::PPOS_W-1:0] pos_s1,
	input  logic                            in_range_s1,
	input  peu_pkg::dom_cfg_t               cfg,
	input  peu_pkg::comp_t                  comp,
	output logic signed [peu_pkg::LV_W-1:0] value_s4
);
	import peu_pkg::*;

	localparam int PROD_W = SLOPE_W + SPAN_W;
	localparam int V_W = FALL_W + 3;

	region_t region_s2, region_s3;
	logic [SPAN_W-1:0] dlt_s2;
	logic in_range_s2, in_range_s3;
	logic [FALL_W-1:0] fall_s3;

	logic signed [DIST_W-1:0] pos, summit, lo, hi, step, p, b, left, right, sep, dd;
	region_t region;
	logic [SLOPE_W-1:0] slope;
	logic [PROD_W-1:0] prod;
	logic signed [V_W-1:0] v, mx, mn, de, fall;

	// stage 2: distance to summit and region
	always_comb begin
		pos = DIST_W'(pos_s1);
		summit = DIST_W'(comp.summit);
		lo = DIST_W'(cfg.low);
		hi = DIST_W'(cfg.high);
		step = $signed(DIST_W'(cfg.step));
		p = $signed(DIST_W'(comp.peak_span));
		b = $signed(DIST_W'(comp.base_span));
		left = '0;
		right = '0;
		if (!cfg.wrap) begin
			sep = (summit >= pos) ? summit - pos : pos - summit;
		end else begin
			if (summit > pos) begin
				right = summit - pos;
				left = (pos - lo) + (hi - summit) + step;
			end else begin
				left = pos - summit;
				right = (hi - pos) + (summit - lo) + step;
			end
			sep = (left < right) ? left : right;
		end
		if (sep < 0) sep = '0;
		if (sep <= p) begin
			region = RG_PEAK;
			dd = sep;
		end else if (sep <= p + b) begin
			region = RG_BASE;
			dd = sep - p;
		end else begin
			region = RG_MIN;
			dd = '0;
		end
	end

	// stage 3: fall = slope * offset, Q16 fraction dropped
	always_comb begin
		slope = (region_s2 == RG_PEAK) ? comp.peak_slope : comp.base_slope;
		prod = PROD_W'(slope) * PROD_W'(dlt_s2);
	end

	// stage 4: value, capped at max, floored for the combiner
	always_comb begin
		mx = V_W'(comp.umax);
		mn = V_W'(comp.umin);
		de = (comp.peak_span == '0) ? '0 : $signed(V_W'(comp.drop));
		fall = $signed(V_W'(fall_s3));
		case (region_s3)
			RG_PEAK: v = mx - fall;
			RG_BASE: v = mx - de - fall;
			default: v = mn;
		endcase
		if (!in_range_s3) v = mn;
		if (v > mx) v = mx;
		if (v < $signed(V_W'(LV_FLOOR))) v = $signed(V_W'(LV_FLOOR));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			region_s2 <= region;
			dlt_s2 <= dd[SPAN_W-1:0];
			in_range_s2 <= in_range_s1;
			region_s3 <= region_s2;
			fall_s3 <= prod[PROD_W-1:16];
			in_range_s3 <= in_range_s2;
			value_s4 <= v[LV_W-1:0];
		end
	end

endmodule

// ----- sv/multi_peak_utility_evaluator.sv -----
// Multi-peak utility evaluator: evaluation requests stream through a five-stage
// pipeline (position multiply, per-component distance, fall multiply, capped
// value, combine into the output register) at one request per cycle while the
// output is not stalled and no load is in progress, and every component has its
// own lane. A load request to a valid slot holds off further requests: two
// 32-step serial dividers compute the peak and base slopes, then the load waits
// until the evaluation pipeline holds no earlier request before it writes its
// table slot and issues its result through the pipeline.
// Output status is 0 ok, 1 load rejected (min not below max), 2 error flag set.
module multi_peak_utility_evaluator #(
	parameter int MAX_COMPONENTS = peu_pkg::MAX_COMP_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [peu_pkg::CFG_IX_W-1:0]         cfg_index,
	input  logic [peu_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [peu_pkg::IX_W-1:0]             point_index,
	input  logic [peu_pkg::SLOT_W-1:0]           slot,
	input  logic signed [peu_pkg::POS_W-1:0]     summit_pos,
	input  logic [peu_pkg::SPAN_W-1:0]           peak_span,
	input  logic [peu_pkg::SPAN_W-1:0]           base_span,
	input  logic [peu_pkg::DROP_W-1:0]           summit_drop,
	input  logic signed [peu_pkg::UTIL_W-1:0]    util_min,
	input  logic signed [peu_pkg::UTIL_W-1:0]    util_max,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [peu_pkg::OUT_W-1:0]     utility,
	output logic [1:0]                           status
);
	import peu_pkg::*;

	localparam int IW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int NW = $clog2(MAX_COMPONENTS + 1);
	localparam int SUM_W = LV_W + 7;
	localparam int MUL_W = IX_W + SPAN_W;

	// configuration registers
	logic signed [POS_W-1:0] domain_low_q, domain_high_q;
	logic [SPAN_W-1:0] domain_step_q;
	logic [CNT_W-1:0] domain_count_q;
	logic wrap_enable_q, combine_max_q;
	logic [CC_W-1:0] comp_count_q;
	dom_cfg_t dom_cfg;

	logic err_q;
	comp_t comp_q [MAX_COMPONENTS];

	// loader
	ld_state_t ld_state_q, ld_state_d;
	logic [SLOT_W-1:0] ld_slot_q;
	comp_t ld_comp_q;
	status_t ld_status_q;
	logic div_start, commit, pipe_empty;
	logic busy_p, busy_b;
	logic [SLOPE_W-1:0] quo_p, quo_b;

	// pipeline
	logic adv, in_acc, is_load, slot_ok;
	logic v_s1, v_s2, v_s3, v_s4;
	op_t op_s1, op_s2, op_s3, op_s4;
	status_t st_s1, st_s2, st_s3, st_s4;
	logic signed [PPOS_W-1:0] pos_s1;
	logic in_range_s1;
	logic signed [LV_W-1:0] val_s4 [MAX_COMPONENTS];
	logic out_valid_q;
	logic signed [OUT_W-1:0] utility_q;
	status_t status_q;

	// load preparation
	logic [IW-1:0] rd_idx;
	comp_t old_c;
	logic rej;
	logic signed [UTIL_W-1:0] nmin, nmax;
	logic signed [UTIL_W+1:0] range, fall_w;
	logic [DROP_W-1:0] dropc, de;
	logic [DROP_W-1:0] fall16;

	// position and combine
	logic [MUL_W-1:0] prod;
	logic signed [PPOS_W-1:0] pos;
	logic [NW-1:0] n_act;
	logic signed [SUM_W-1:0] sum, best, res;

	assign dom_cfg = '{low: domain_low_q, high: domain_high_q,
		step: domain_step_q, wrap: wrap_enable_q};

	assign adv = !out_valid_q || !out_stall;
	assign is_load = (op == OP_LOAD);
	assign slot_ok = int'(slot) < MAX_COMPONENTS;
	assign in_acc = in_valid && !in_stall;
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3 && !v_s4;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			domain_low_q <= '0;
			domain_high_q <= '0;
			domain_step_q <= SPAN_W'(256);
			domain_count_q <= CNT_W'(1);
			wrap_enable_q <= 1'b0;
			combine_max_q <= 1'b0;
			comp_count_q <= CC_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DOMAIN_LOW: domain_low_q <= cfg_data[POS_W-1:0];
				REG_DOMAIN_HIGH: domain_high_q <= cfg_data[POS_W-1:0];
				REG_DOMAIN_STEP: domain_step_q <= cfg_data[SPAN_W-1:0];
				REG_DOMAIN_COUNT: domain_count_q <= cfg_data[CNT_W-1:0];
				REG_WRAP_ENABLE: wrap_enable_q <= cfg_data[0];
				REG_COMBINE_MAX: combine_max_q <= cfg_data[0];
				REG_COMP_COUNT: comp_count_q <= cfg_data[CC_W-1:0];
				default: ;
			endcase
		end
	end

	// load request: clamp drop, form slope dividends
	always_comb begin
		rd_idx = slot_ok ? IW'(slot) : '0;
		old_c = comp_q[rd_idx];
		rej = util_min >= util_max;
		nmin = rej ? old_c.umin : util_min;
		nmax = rej ? old_c.umax : util_max;
		range = (UTIL_W+2)'(nmax) - (UTIL_W+2)'(nmin);
		if (range < 0) range = '0;
		dropc = ($signed({2'b0, summit_drop}) > range) ? range[DROP_W-1:0] : summit_drop;
		de = (peak_span == '0) ? '0 : dropc;
		fall_w = range - $signed({2'b0, de});
		if (fall_w < 0) fall_w = '0;
		fall16 = fall_w[DROP_W-1:0];
	end

	peu_div #(.NUM_W(SLOPE_W), .DEN_W(SPAN_W)) u_div_peak (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({de, 16'b0}), .den(peak_span), .busy(busy_p), .quo(quo_p)
	);

	peu_div #(.NUM_W(SLOPE_W), .DEN_W(SPAN_W)) u_div_base (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({fall16, 16'b0}), .den(base_span), .busy(busy_b), .quo(quo_b)
	);

	// loader next state
	always_comb begin
		ld_state_d = ld_state_q;
		case (ld_state_q)
			LD_IDLE: if (in_acc && is_load && slot_ok) ld_state_d = LD_DIV;
			LD_DIV: if (!busy_p && !busy_b) ld_state_d = LD_COMMIT;
			LD_COMMIT: if (adv && pipe_empty) ld_state_d = LD_IDLE;
			default: ld_state_d = LD_IDLE;
		endcase
	end

	// loader outputs
	always_comb begin
		div_start = 1'b0;
		commit = 1'b0;
		in_stall = 1'b1;
		case (ld_state_q)
			LD_IDLE: begin
				in_stall = !adv;
				div_start = in_valid && adv && is_load && slot_ok;
			end
			LD_COMMIT: commit = adv && pipe_empty;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_state_q <= LD_IDLE;
			err_q <= 1'b0;
		end else begin
			ld_state_q <= ld_state_d;
			if (in_acc && is_load && (!slot_ok || rej)) err_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			ld_slot_q <= slot;
			ld_comp_q <= '{summit: summit_pos, peak_span: peak_span,
				base_span: base_span, drop: dropc, umin: nmin, umax: nmax,
				peak_slope: '0, base_slope: '0};
			ld_status_q <= rej ? ST_REJECT : (err_q ? ST_ERROR : ST_OK);
		end
	end

	// component table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_COMPONENTS; c++) begin
				comp_q[c] <= '{summit: '0, peak_span: '0, base_span: '0, drop: '0,
					umin: '0, umax: UTIL_RESET_MAX, peak_slope: '0, base_slope: '0};
			end
		end else if (commit) begin
			for (int c = 0; c < MAX_COMPONENTS; c++) begin
				if (c == int'(ld_slot_q)) begin
					comp_q[c] <= '{summit: ld_comp_q.summit,
						peak_span: ld_comp_q.peak_span,
						base_span: ld_comp_q.base_span,
						drop: ld_comp_q.drop, umin: ld_comp_q.umin,
						umax: ld_comp_q.umax,
						peak_slope: (ld_comp_q.peak_span == '0) ? '0 : quo_p,
						base_slope: (ld_comp_q.base_span == '0) ? '0 : quo_b};
				end
			end
		end
	end

	// stage 1: point position
	always_comb begin
		prod = MUL_W'(point_index) * MUL_W'(domain_step_q);
		pos = $signed({2'b0, prod}) + PPOS_W'(domain_low_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_acc && (!is_load || !slot_ok) || commit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (commit) begin
				op_s1 <= OP_LOAD;
				st_s1 <= ld_status_q;
			end else if (is_load) begin
				op_s1 <= OP_LOAD;
				st_s1 <= ST_ERROR;
			end else begin
				op_s1 <= OP_EVAL;
				st_s1 <= err_q ? ST_ERROR : ST_OK;
			end
			pos_s1 <= pos;
			in_range_s1 <= {1'b0, point_index} < domain_count_q;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			op_s4 <= op_s3;
			st_s2 <= st_s1;
			st_s3 <= st_s2;
			st_s4 <= st_s3;
			utility_q <= (op_s4 == OP_LOAD) ? '0 : res[OUT_W-1:0];
			status_q <= st_s4;
		end
	end

	// stages 2 to 4: one lane per component
	for (genvar g = 0; g < MAX_COMPONENTS; g++) begin : g_lane
		peu_lane u_lane (
			.clk(clk), .adv(adv), .pos_s1(pos_s1), .in_range_s1(in_range_s1),
			.cfg(dom_cfg), .comp(comp_q[g]), .value_s4(val_s4[g])
		);
	end

	// stage 5: combine active lanes by max or saturating sum
	always_comb begin
		if (comp_count_q == '0) n_act = NW'(1);
		else if (int'(comp_count_q) > MAX_COMPONENTS) n_act = NW'(MAX_COMPONENTS);
		else n_act = NW'(comp_count_q);
		sum = '0;
		best = SUM_W'(val_s4[0]);
		for (int c = 0; c < MAX_COMPONENTS; c++) begin
			if (c < int'(n_act)) begin
				sum = sum + SUM_W'(val_s4[c]);
				if (SUM_W'(val_s4[c]) > best) best = SUM_W'(val_s4[c]);
			end
		end
		res = combine_max_q ? best : sum;
		if (res < SUM_W'(OUT_MIN)) res = SUM_W'(OUT_MIN);
		if (res > SUM_W'(OUT_MAX)) res = SUM_W'(OUT_MAX);
	end

	assign out_valid = out_valid_q;
	assign utility = utility_q;
	assign status = status_q;

`ifndef SYNTHESIS
	// a table write never overtakes an evaluation in flight
	a_commit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!v_s1 && !v_s2 && !v_s3 && !v_s4))
		else $error("table written with requests in flight");

	// no request is taken while a load is in progress
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_state_q != LD_IDLE) |-> in_stall)
		else $error("request taken during load");

	// dividers only run in the divide state
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_p || busy_b) |-> (ld_state_q == LD_DIV))
		else $error("divider busy outside divide state");

	// loads report zero utility
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4 && op_s4 == OP_LOAD) |=> (out_valid_q && utility_q == '0))
		else $error("load result with nonzero utility");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the multi-peak utility evaluator.
module tb_top;
	import peu_pkg::*;

	localparam int NCOMP = MAX_COMP_DEF;

	typedef struct {
		op_t op;
		logic [IX_W-1:0] ix;
		logic [SLOT_W-1:0] slot;
		logic signed [POS_W-1:0] summit;
		logic [SPAN_W-1:0] pspan;
		logic [SPAN_W-1:0] bspan;
		logic [DROP_W-1:0] drop;
		logic signed [UTIL_W-1:0] lo;
		logic signed [UTIL_W-1:0] hi;
	} request_t;

	// Utility predictor with its own copy of the table and domain registers
	class peak_table_scoreboard;
		longint dom_low, dom_high;
		longint unsigned dom_step, dom_count;
		bit wrap, by_max;
		int unsigned ccount;
		longint c_summit[NCOMP], c_pspan[NCOMP], c_bspan[NCOMP];
		longint c_drop[NCOMP], c_min[NCOMP], c_max[NCOMP];
		longint unsigned c_pslope[NCOMP], c_bslope[NCOMP];
		bit err_flag;
		logic signed [OUT_W-1:0] util_due[$];
		status_t status_due[$];
		int mismatches;
		int loads, evals;

		function new();
			dom_low = 0;
			dom_high = 0;
			dom_step = 256;
			dom_count = 1;
			wrap = 0;
			by_max = 0;
			ccount = 1;
			for (int c = 0; c < NCOMP; c++) begin
				c_summit[c] = 0;
				c_pspan[c] = 0;
				c_bspan[c] = 0;
				c_drop[c] = 0;
				c_min[c] = 0;
				c_max[c] = 25600;
				c_pslope[c] = 0;
				c_bslope[c] = 0;
			end
			err_flag = 0;
			mismatches = 0;
			loads = 0;
			evals = 0;
		endfunction

		function void set_reg(logic [CFG_IX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_DOMAIN_LOW: dom_low = longint'($signed(data));
				REG_DOMAIN_HIGH: dom_high = longint'($signed(data));
				REG_DOMAIN_STEP: dom_step = longint'(data[SPAN_W-1:0]);
				REG_DOMAIN_COUNT: dom_count = longint'(data[CNT_W-1:0]);
				REG_WRAP_ENABLE: wrap = data[0];
				REG_COMBINE_MAX: by_max = data[0];
				REG_COMP_COUNT: ccount = 32'(data[CC_W-1:0]);
				default: ;
			endcase
		endfunction

		// Queue the result expected for one request
		function void due_add(logic signed [OUT_W-1:0] u, status_t st);
			util_due = {util_due, u};
			status_due = {status_due, st};
		endfunction

		function longint eff_drop(int c);
			return (c_pspan[c] == 0) ? 0 : c_drop[c];
		endfunction

		function longint component_value(int c, longint unsigned ix);
			longint pos, sep, lft, rgt, v;
			if (ix >= dom_count)
				return c_min[c];
			pos = longint'(ix * dom_step) + dom_low;
			if (!wrap) begin
				sep = (c_summit[c] >= pos) ? c_summit[c] - pos : pos - c_summit[c];
			end else if (c_summit[c] > pos) begin
				rgt = c_summit[c] - pos;
				lft = (pos - dom_low) + (dom_high - c_summit[c]) + longint'(dom_step);
				sep = (lft < rgt) ? lft : rgt;
			end else begin
				lft = pos - c_summit[c];
				rgt = (dom_high - pos) + (c_summit[c] - dom_low) + longint'(dom_step);
				sep = (lft < rgt) ? lft : rgt;
			end
			if (sep < 0)
				sep = 0;
			if (sep <= c_pspan[c])
				v = c_max[c] - longint'((c_pslope[c] * longint'(sep)) >> 16);
			else if (sep <= c_pspan[c] + c_bspan[c])
				v = c_max[c] - eff_drop(c)
					- longint'((c_bslope[c] * longint'(sep - c_pspan[c])) >> 16);
			else
				v = c_min[c];
			if (v > c_max[c])
				v = c_max[c];
			return v;
		endfunction

		// Update the table or compute the combined utility for one request
		function void note_request(request_t r);
			longint best, total, v, fall, range;
			int n, c;
			status_t st;
			if (r.op == OP_LOAD) begin
				loads++;
				c = 32'(r.slot);
				st = ST_OK;
				c_summit[c] = longint'(r.summit);
				c_pspan[c] = longint'(r.pspan);
				c_bspan[c] = longint'(r.bspan);
				if (r.lo >= r.hi) begin
					err_flag = 1;
					st = ST_REJECT;
				end else begin
					c_min[c] = longint'(r.lo);
					c_max[c] = longint'(r.hi);
				end
				range = c_max[c] - c_min[c];
				if (range < 0)
					range = 0;
				c_drop[c] = (longint'(r.drop) > range) ? range : longint'(r.drop);
				fall = c_max[c] - eff_drop(c) - c_min[c];
				if (fall < 0)
					fall = 0;
				c_pslope[c] = (c_pspan[c] == 0) ? 0 :
					(longint'(eff_drop(c)) << 16) / c_pspan[c];
				c_bslope[c] = (c_bspan[c] == 0) ? 0 : (fall << 16) / c_bspan[c];
				if (st == ST_OK && err_flag)
					st = ST_ERROR;
				due_add('0, st);
			end else begin
				evals++;
				n = ccount;
				if (n < 1)
					n = 1;
				if (n > NCOMP)
					n = NCOMP;
				best = 0;
				total = 0;
				for (c = 0; c < n; c++) begin
					v = component_value(c, longint'(r.ix));
					if (c == 0 || v > best)
						best = v;
					total += v;
				end
				v = by_max ? best : total;
				if (v < OUT_MIN)
					v = OUT_MIN;
				if (v > OUT_MAX)
					v = OUT_MAX;
				due_add(v[OUT_W-1:0], err_flag ? ST_ERROR : ST_OK);
			end
		endfunction

		function void check_result(logic signed [OUT_W-1:0] u, logic [1:0] s);
			logic signed [OUT_W-1:0] eu;
			status_t es;
			if (util_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: utility %0d status %0d", u, s);
				return;
			end
			eu = util_due.pop_front();
			es = status_due.pop_front();
			if (u !== eu || s !== es) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: utility exp %0d got %0d, status exp %0d got %0d",
						eu, u, es, s);
			end
		endfunction

		function int pending();
			return util_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic op;
	logic [IX_W-1:0] point_index;
	logic [SLOT_W-1:0] slot;
	logic signed [POS_W-1:0] summit_pos;
	logic [SPAN_W-1:0] peak_span, base_span;
	logic [DROP_W-1:0] summit_drop;
	logic signed [UTIL_W-1:0] util_min, util_max;
	logic out_valid, out_stall;
	logic signed [OUT_W-1:0] utility;
	logic [1:0] status;

	peak_table_scoreboard sb;
	int idle_pct;
	int phases;

	multi_peak_utility_evaluator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .point_index(point_index), .slot(slot), .summit_pos(summit_pos),
		.peak_span(peak_span), .base_span(base_span), .summit_drop(summit_drop),
		.util_min(util_min), .util_max(util_max),
		.out_valid(out_valid), .out_stall(out_stall),
		.utility(utility), .status(status)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

	// Result-side backpressure
	always @(negedge clk) begin
		out_stall = (idle_pct > 0) ? ($urandom_range(99) < idle_pct) : 1'b0;
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(utility, status);
	end

	task automatic write_reg(logic [CFG_IX_W-1:0] idx, longint value);
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_index = idx;
		cfg_data = value[CFG_W-1:0];
		sb.set_reg(idx, value[CFG_W-1:0]);
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	// Let the block drain before touching the registers
	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_domain(longint lo, longint stp, longint cnt, bit wr, bit mx, int cc);
		drain();
		write_reg(REG_DOMAIN_LOW, lo);
		write_reg(REG_DOMAIN_HIGH, lo + stp * (cnt - 1));
		write_reg(REG_DOMAIN_STEP, stp);
		write_reg(REG_DOMAIN_COUNT, cnt);
		write_reg(REG_WRAP_ENABLE, wr);
		write_reg(REG_COMBINE_MAX, mx);
		write_reg(REG_COMP_COUNT, cc);
		phases++;
	endtask

	// Present one request and hold it until accepted
	task automatic send(request_t r);
		@(negedge clk);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		op = r.op;
		point_index = r.ix;
		slot = r.slot;
		summit_pos = r.summit;
		peak_span = r.pspan;
		base_span = r.bspan;
		summit_drop = r.drop;
		util_min = r.lo;
		util_max = r.hi;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
	endtask

	task automatic send_eval(logic [IX_W-1:0] ix);
		request_t r;
		r.op = OP_EVAL;
		r.ix = ix;
		r.slot = SLOT_W'($urandom);
		r.summit = POS_W'($urandom);
		r.pspan = SPAN_W'($urandom);
		r.bspan = SPAN_W'($urandom);
		r.drop = DROP_W'($urandom);
		r.lo = UTIL_W'($urandom);
		r.hi = UTIL_W'($urandom);
		send(r);
	endtask

	task automatic send_load(logic [SLOT_W-1:0] s, longint sm, longint ps, longint bs,
			longint dr, longint lo, longint hi);
		request_t r;
		r.op = OP_LOAD;
		r.ix = IX_W'($urandom);
		r.slot = s;
		r.summit = sm[POS_W-1:0];
		r.pspan = ps[SPAN_W-1:0];
		r.bspan = bs[SPAN_W-1:0];
		r.drop = dr[DROP_W-1:0];
		r.lo = lo[UTIL_W-1:0];
		r.hi = hi[UTIL_W-1:0];
		send(r);
	endtask

	// Random traffic shaped around the current domain
	task automatic random_traffic(int count);
		longint lo, hi, stp;
		longint unsigned cnt;
		for (int k = 0; k < count; k++) begin
			stp = sb.dom_step;
			cnt = sb.dom_count;
			if ($urandom_range(99) < 18) begin
				if ($urandom_range(99) < 15) begin
					send_load(SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				end else begin
					lo = $signed(16'($urandom));
					hi = $signed(16'($urandom));
					if ($urandom_range(99) < 88) begin
						if (lo > hi) begin
							lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
						end
						if (lo == hi)
							hi = (lo == 32767) ? hi : hi + 1;
					end
					send_load(SLOT_W'($urandom),
						sb.dom_low + stp * $urandom_range(cnt - 1) + $signed(5'($urandom)),
						stp * $urandom_range(6) + $urandom_range(3),
						stp * $urandom_range(10) + $urandom_range(3),
						($urandom_range(1)) ? $urandom_range(600) : $urandom, lo, hi);
				end
			end else if ($urandom_range(99) < 85) begin
				send_eval((cnt > 65536) ? IX_W'($urandom) : IX_W'($urandom_range(cnt - 1)));
			end else begin
				send_eval(IX_W'($urandom));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		op = OP_EVAL;
		point_index = '0;
		slot = '0;
		summit_pos = '0;
		peak_span = '0;
		base_span = '0;
		summit_drop = '0;
		util_min = '0;
		util_max = '0;
		idle_pct = 30;
		phases = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset table: single point, default component
		send_eval(0);
		send_eval(1);
		send_eval(16'hffff);

		// Directed loads: extremes, rejection, zero spans, drop clamp
		set_domain(0, 256, 64, 0, 0, 3);
		send_load(0, 2560, 512, 1024, 256, -512, 1024);
		send_load(7, 8388607, 8388607, 8388607, 65535, -32768, 32767);
		send_load(1, -8388608, 0, 0, 65535, 100, 100);
		send_eval(10);
		send_load(2, 4096, 0, 768, 500, 300, 200);
		send_load(3, 1280, 768, 0, 65535, -100, 100);
		send_load(4, 0, 0, 0, 0, -32768, -32767);
		send_eval(0);
		send_eval(5);
		send_eval(12);
		send_eval(63);
		send_eval(64);
		set_domain(0, 256, 64, 0, 0, 8);
		send_eval(3);
		send_eval(20);
		set_domain(0, 256, 64, 1, 1, 8);
		send_eval(0);
		send_eval(63);

		random_traffic(200);
		set_domain(-1000, 100, 200, 1, 1, 8);
		random_traffic(200);
		set_domain(-8388608, 8388607, 3, 1, 0, 15);
		random_traffic(150);
		set_domain(5000, 1, 65536, 0, 1, 0);
		random_traffic(200);
		// Inconsistent high/low so wrapped distances can go negative
		set_domain(1000, 50, 100, 1, 0, 5);
		write_reg(REG_DOMAIN_HIGH, -1000);
		random_traffic(150);
		// Back-to-back traffic, no idling on either side
		set_domain(-2560, 256, 40, 1, 0, 8);
		idle_pct = 0;
		random_traffic(250);
		idle_pct = 30;
		set_domain(0, 8388607, 2, 0, 0, 8);
		write_reg(REG_DOMAIN_LOW, 8388607);
		random_traffic(150);

		@(negedge clk);
		in_valid = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d loads and %0d evaluations over %0d register settings",
			sb.loads, sb.evals, phases);
		$display("%0d mismatching results", sb.mismatches);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
